// ===== sv/ray_sphere_intersect_defines.svh =====
// assertion helpers for the ray/sphere tester
`ifndef RAY_SPHERE_INTERSECT_DEFINES_SVH
`define RAY_SPHERE_INTERSECT_DEFINES_SVH

// clocked assertion, disabled while reset is low
`define RSI_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("rsi assertion failed");

// same, on the block's own clock and reset names
`define RSI_ASSERT_STD(lbl, prop) `RSI_ASSERT(lbl, i_clk, i_rst_n, prop)

`endif

// ===== sv/rsi_pkg.sv =====
package rsi_pkg;

    localparam int DIR_BITS       = 16;
    localparam int COORD_BITS_DEF = 24;
    localparam int DIR_FRAC_DEF   = 14;
    localparam int CFG_IDX_BITS   = 2;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_CENTER_X = 2'd0,
        CFG_CENTER_Y = 2'd1,
        CFG_CENTER_Z = 2'd2,
        CFG_RADIUS   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic valid;
        logic miss;
    } t_flags;

    // rounded projection magnitude width
    function automatic int p8_w(input int c, input int f);
        return c + 18 - f;
    endfunction

    // width of pp + r2 - len2
    function automatic int sqrt_in_w(input int c, input int f);
        int a;
        int b;
        a = 2 * p8_w(c, f);
        b = 2 * c + 4;
        return ((a > b) ? a : b) + 1;
    endfunction

    function automatic int root_w(input int c, input int f);
        return (sqrt_in_w(c, f) + 1) >> 1;
    endfunction

    // start to result strobe, in cycles
    function automatic int latency(input int c, input int f);
        return root_w(c, f) + 7;
    endfunction

endpackage

// ===== sv/rsi_geom.sv =====
module rsi_geom #(
    parameter int COORD_BITS    = rsi_pkg::COORD_BITS_DEF,
    parameter int DIR_FRAC_BITS = rsi_pkg::DIR_FRAC_DEF,
    parameter int P8W           = rsi_pkg::p8_w(COORD_BITS, DIR_FRAC_BITS),
    parameter int SW            = rsi_pkg::sqrt_in_w(COORD_BITS, DIR_FRAC_BITS)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic signed [COORD_BITS-1:0]        i_origin_x,
    input  logic signed [COORD_BITS-1:0]        i_origin_y,
    input  logic signed [COORD_BITS-1:0]        i_origin_z,
    input  logic signed [rsi_pkg::DIR_BITS-1:0] i_dir_x,
    input  logic signed [rsi_pkg::DIR_BITS-1:0] i_dir_y,
    input  logic signed [rsi_pkg::DIR_BITS-1:0] i_dir_z,
    input  logic        [COORD_BITS-1:0]        i_max_dist,
    input  logic signed [COORD_BITS-1:0]        i_center_x,
    input  logic signed [COORD_BITS-1:0]        i_center_y,
    input  logic signed [COORD_BITS-1:0]        i_center_z,
    input  logic        [COORD_BITS-2:0]        i_radius,
    output rsi_pkg::t_flags                     o_flags,
    output logic        [SW-1:0]                o_rad,
    output logic        [P8W-1:0]               o_p8,
    output logic        [COORD_BITS-1:0]        o_max_dist
);
    import rsi_pkg::*;

    localparam int C   = COORD_BITS;
    localparam int F   = DIR_FRAC_BITS;
    localparam int OW  = C + 1;
    localparam int PRW = OW + DIR_BITS;
    localparam int PW  = PRW + 2;
    localparam int SQW = 2 * OW;
    localparam int LW  = SQW + 2;
    localparam int RW  = 2 * (C - 1);
    localparam int PPW = 2 * P8W;

    // stage 1: offsets
    logic                  r_v1;
    logic signed [OW-1:0]  r_ox, r_oy, r_oz;
    logic signed [DIR_BITS-1:0] r_dx, r_dy, r_dz;
    logic [C-1:0]          r_md1;
    logic [C-2:0]          r_rad1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
        end
        r_ox   <= {i_center_x[C-1], i_center_x} - {i_origin_x[C-1], i_origin_x};
        r_oy   <= {i_center_y[C-1], i_center_y} - {i_origin_y[C-1], i_origin_y};
        r_oz   <= {i_center_z[C-1], i_center_z} - {i_origin_z[C-1], i_origin_z};
        r_dx   <= i_dir_x;
        r_dy   <= i_dir_y;
        r_dz   <= i_dir_z;
        r_md1  <= i_max_dist;
        r_rad1 <= i_radius;
    end

    // stage 2: products and squares
    logic [OW-1:0] n_ax, n_ay, n_az;
    always_comb begin
        n_ax = r_ox[OW-1] ? OW'(-r_ox) : OW'(r_ox);
        n_ay = r_oy[OW-1] ? OW'(-r_oy) : OW'(r_oy);
        n_az = r_oz[OW-1] ? OW'(-r_oz) : OW'(r_oz);
    end

    logic                  r_v2;
    logic signed [PRW-1:0] r_px, r_py, r_pz;
    logic [SQW-1:0]        r_sx, r_sy, r_sz;
    logic [RW-1:0]         r_r2_2;
    logic [C-1:0]          r_md2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_px   <= PRW'(r_ox * r_dx);
        r_py   <= PRW'(r_oy * r_dy);
        r_pz   <= PRW'(r_oz * r_dz);
        r_sx   <= n_ax * n_ax;
        r_sy   <= n_ay * n_ay;
        r_sz   <= n_az * n_az;
        r_r2_2 <= r_rad1 * r_rad1;
        r_md2  <= r_md1;
    end

    // stage 3: dot product and squared length
    logic                 r_v3;
    logic signed [PW-1:0] r_proj;
    logic [LW-1:0]        r_len2_3;
    logic [RW-1:0]        r_r2_3;
    logic [C-1:0]         r_md3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
        r_proj   <= PW'(r_px) + PW'(r_py) + PW'(r_pz);
        r_len2_3 <= LW'(r_sx) + LW'(r_sy) + LW'(r_sz);
        r_r2_3   <= r_r2_2;
        r_md3    <= r_md2;
    end

    // stage 4: round projection magnitude to integer
    logic [PW-1:0] n_mag;
    logic [PW-1:0] n_rnd;
    always_comb begin
        n_mag = r_proj[PW-1] ? PW'(-r_proj) : PW'(r_proj);
        n_rnd = n_mag + (PW'(1) << (F - 1));
    end

    logic            r_v4;
    logic [P8W-1:0]  r_p8_4;
    logic [LW-1:0]   r_len2_4;
    logic [RW-1:0]   r_r2_4;
    logic [C-1:0]    r_md4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else begin
            r_v4 <= r_v3;
        end
        r_p8_4   <= n_rnd[F +: P8W];
        r_len2_4 <= r_len2_3;
        r_r2_4   <= r_r2_3;
        r_md4    <= r_md3;
    end

    // stage 5: squared projection
    logic            r_v5;
    logic [PPW-1:0]  r_pp;
    logic [P8W-1:0]  r_p8_5;
    logic [LW-1:0]   r_len2_5;
    logic [RW-1:0]   r_r2_5;
    logic [C-1:0]    r_md5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else begin
            r_v5 <= r_v4;
        end
        r_pp     <= r_p8_4 * r_p8_4;
        r_p8_5   <= r_p8_4;
        r_len2_5 <= r_len2_4;
        r_r2_5   <= r_r2_4;
        r_md5    <= r_md4;
    end

    // stage 6: miss test and radicand
    logic [SW-1:0] n_sum;
    logic [SW-1:0] n_len2;
    always_comb begin
        n_sum  = SW'(r_pp) + SW'(r_r2_5);
        n_len2 = SW'(r_len2_5);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_flags.valid <= 1'b0;
        end else begin
            o_flags.valid <= r_v5;
        end
        o_flags.miss <= n_len2 > n_sum;
        o_rad        <= n_sum - n_len2;
        o_p8         <= r_p8_5;
        o_max_dist   <= r_md5;
    end

endmodule

// ===== sv/rsi_sqrt.sv =====
module rsi_sqrt #(
    parameter int SW  = 57,
    parameter int QW  = 29,
    parameter int P8W = 28,
    parameter int MDW = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rsi_pkg::t_flags    i_flags,
    input  logic [SW-1:0]      i_rad,
    input  logic [P8W-1:0]     i_p8,
    input  logic [MDW-1:0]     i_max_dist,
    output rsi_pkg::t_flags    o_flags,
    output logic [QW-1:0]      o_root,
    output logic [P8W-1:0]     o_p8,
    output logic [MDW-1:0]     o_max_dist
);
    import rsi_pkg::*;

    localparam int VW = 2 * QW;

    // one root bit per stage, msb first; the last stage keeps no remainder
    logic [VW-1:0]  r_rem [QW-1];
    logic [QW-1:0]  r_q   [QW];
    t_flags         r_fl  [QW];
    logic [P8W-1:0] r_p8  [QW];
    logic [MDW-1:0] r_md  [QW];

    for (genvar s = 0; s < QW; s++) begin : g_stage
        localparam int K = QW - 1 - s;
        logic [VW-1:0]  w_rem;
        logic [QW-1:0]  w_q;
        t_flags         w_fl;
        logic [P8W-1:0] w_p8;
        logic [MDW-1:0] w_md;
        logic [VW:0]    w_trial;
        logic           w_take;

        if (s == 0) begin : g_first
            assign w_rem = VW'(i_rad);
            assign w_q   = '0;
            assign w_fl  = i_flags;
            assign w_p8  = i_p8;
            assign w_md  = i_max_dist;
        end else begin : g_next
            assign w_rem = r_rem[s-1];
            assign w_q   = r_q[s-1];
            assign w_fl  = r_fl[s-1];
            assign w_p8  = r_p8[s-1];
            assign w_md  = r_md[s-1];
        end

        // (q + 2^k)^2 - q^2 = q*2^(k+1) + 4^k
        assign w_trial = ((VW+1)'(w_q) << (K + 1)) + ((VW+1)'(1) << (2 * K));
        assign w_take  = ({1'b0, w_rem} >= w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_fl[s].valid <= 1'b0;
            end else begin
                r_fl[s].valid <= w_fl.valid;
            end
            r_fl[s].miss <= w_fl.miss;
            r_q[s]       <= w_take ? (w_q | (QW'(1) << K)) : w_q;
            r_p8[s]      <= w_p8;
            r_md[s]      <= w_md;
        end

        if (s < QW - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                r_rem[s] <= w_take ? VW'({1'b0, w_rem} - w_trial) : w_rem;
            end
        end
    end

    assign o_flags    = r_fl[QW-1];
    assign o_root     = r_q[QW-1];
    assign o_p8       = r_p8[QW-1];
    assign o_max_dist = r_md[QW-1];

endmodule

// ===== sv/ray_sphere_intersect.sv =====
// channel  | ports                                   | handshake
// ---------+-----------------------------------------+--------------------------
// request  | i_start, o_busy, i_origin_*, i_dir_*,   | taken when i_start && !o_busy
//          | i_max_dist                              |
// config   | i_cfg_valid, o_cfg_ready, i_cfg_idx,    | taken when valid && ready
//          | i_cfg_data                              |
// result   | o_valid, o_hit, o_hit_dist              | one cycle strobe, no stall
//
// one request per cycle; each result passes through the six geometry stages,
// one square root stage per root bit and the output register
// o_busy and o_cfg_ready are constant, the pipeline never stalls
// synchronous active-low reset clears the stage valid bits and the sphere centre, and sets the radius to 256
module ray_sphere_intersect #(
    parameter int COORD_BITS    = rsi_pkg::COORD_BITS_DEF,
    parameter int DIR_FRAC_BITS = rsi_pkg::DIR_FRAC_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    output logic                                  o_busy,
    input  logic signed [COORD_BITS-1:0]          i_origin_x,
    input  logic signed [COORD_BITS-1:0]          i_origin_y,
    input  logic signed [COORD_BITS-1:0]          i_origin_z,
    input  logic signed [rsi_pkg::DIR_BITS-1:0]   i_dir_x,
    input  logic signed [rsi_pkg::DIR_BITS-1:0]   i_dir_y,
    input  logic signed [rsi_pkg::DIR_BITS-1:0]   i_dir_z,
    input  logic        [COORD_BITS-1:0]          i_max_dist,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic        [rsi_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic        [COORD_BITS-1:0]          i_cfg_data,
    output logic                                  o_valid,
    output logic                                  o_hit,
    output logic        [COORD_BITS-1:0]          o_hit_dist
);
    import rsi_pkg::*;

    localparam int C   = COORD_BITS;
    localparam int P8W = p8_w(COORD_BITS, DIR_FRAC_BITS);
    localparam int SW  = sqrt_in_w(COORD_BITS, DIR_FRAC_BITS);
    localparam int QW  = root_w(COORD_BITS, DIR_FRAC_BITS);
    localparam int EW  = (P8W > QW) ? P8W : QW;
    // one pad bit above the wider of the operand and output widths
    localparam int WW  = ((EW > C) ? EW : C) + 1;

    // no back pressure anywhere
    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    // sphere registers
    logic signed [C-1:0] r_center_x, r_center_y, r_center_z;
    logic        [C-2:0] r_radius;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_y <= '0;
            r_center_z <= '0;
            r_radius   <= (C-1)'(256);
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_CENTER_X: r_center_x <= i_cfg_data;
                CFG_CENTER_Y: r_center_y <= i_cfg_data;
                CFG_CENTER_Z: r_center_z <= i_cfg_data;
                CFG_RADIUS:   r_radius   <= i_cfg_data[C-2:0];
                default: ;
            endcase
        end
    end

    // geometry: offset, dot product, squares, miss test
    t_flags         w_g_flags;
    logic [SW-1:0]  w_g_rad;
    logic [P8W-1:0] w_g_p8;
    logic [C-1:0]   w_g_md;

    rsi_geom #(
        .COORD_BITS   (COORD_BITS),
        .DIR_FRAC_BITS(DIR_FRAC_BITS),
        .P8W          (P8W),
        .SW           (SW)
    ) u_geom (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_start && !o_busy),
        .i_origin_x (i_origin_x),
        .i_origin_y (i_origin_y),
        .i_origin_z (i_origin_z),
        .i_dir_x    (i_dir_x),
        .i_dir_y    (i_dir_y),
        .i_dir_z    (i_dir_z),
        .i_max_dist (i_max_dist),
        .i_center_x (r_center_x),
        .i_center_y (r_center_y),
        .i_center_z (r_center_z),
        .i_radius   (r_radius),
        .o_flags    (w_g_flags),
        .o_rad      (w_g_rad),
        .o_p8       (w_g_p8),
        .o_max_dist (w_g_md)
    );

    // half chord: pipelined floor square root
    t_flags         w_s_flags;
    logic [QW-1:0]  w_s_root;
    logic [P8W-1:0] w_s_p8;
    logic [C-1:0]   w_s_md;

    rsi_sqrt #(
        .SW (SW),
        .QW (QW),
        .P8W(P8W),
        .MDW(C)
    ) u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_flags    (w_g_flags),
        .i_rad      (w_g_rad),
        .i_p8       (w_g_p8),
        .i_max_dist (w_g_md),
        .o_flags    (w_s_flags),
        .o_root     (w_s_root),
        .o_p8       (w_s_p8),
        .o_max_dist (w_s_md)
    );

    // entry distance, clamp at zero, saturate to output range
    logic [WW-1:0] n_p8, n_half, n_diff, n_limit;
    logic [C-1:0]  n_dist;
    logic          n_hit;

    always_comb begin
        n_p8    = WW'(w_s_p8);
        n_half  = WW'(w_s_root);
        n_limit = WW'({C{1'b1}});
        n_diff  = (n_p8 > n_half) ? (n_p8 - n_half) : '0;
        n_dist  = (n_diff > n_limit) ? {C{1'b1}} : n_diff[C-1:0];
        // geometric miss reports zero distance
        if (w_s_flags.miss) begin
            n_dist = '0;
        end
        n_hit = w_s_flags.valid && !w_s_flags.miss && (n_dist <= w_s_md);
    end

    logic         r_valid;
    logic         r_hit;
    logic [C-1:0] r_dist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_hit   <= 1'b0;
        end else begin
            r_valid <= w_s_flags.valid;
            r_hit   <= n_hit;
        end
        r_dist <= n_dist;
    end

    assign o_valid    = r_valid;
    assign o_hit      = r_hit;
    assign o_hit_dist = r_dist;

endmodule

// ===== sv/rsi_checker.sv =====
`include "ray_sphere_intersect_defines.svh"

module rsi_checker #(
    parameter int COORD_BITS    = rsi_pkg::COORD_BITS_DEF,
    parameter int DIR_FRAC_BITS = rsi_pkg::DIR_FRAC_DEF
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input logic o_busy,
    input logic o_cfg_ready,
    input logic o_valid,
    input logic o_hit
);
    import rsi_pkg::*;

    localparam int LAT = latency(COORD_BITS, DIR_FRAC_BITS);

    // every request yields a result after the fixed latency
    `RSI_ASSERT_STD(a_result_follows, (i_start && !o_busy) |-> ##LAT o_valid)

    // no result without a request
    `RSI_ASSERT_STD(a_no_extra, o_valid |-> $past(i_start && !o_busy, LAT))

    // hit only flagged on a result strobe
    `RSI_ASSERT(a_hit_strobed, i_clk, i_rst_n, o_hit |-> o_valid)

    // config always ready and requests never held off
    `RSI_ASSERT_STD(a_ready_const, o_cfg_ready && !o_busy)

endmodule

bind ray_sphere_intersect rsi_checker #(
    .COORD_BITS   (COORD_BITS),
    .DIR_FRAC_BITS(DIR_FRAC_BITS)
) u_rsi_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_start    (i_start),
    .o_busy     (o_busy),
    .o_cfg_ready(o_cfg_ready),
    .o_valid    (o_valid),
    .o_hit      (o_hit)
);
